@@ design/bounded_frequency_sorted_list_assert.svh @@
// Assertion macros shared by the ranked tally list RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef BOUNDED_FREQUENCY_SORTED_LIST_ASSERT_SVH
`define BOUNDED_FREQUENCY_SORTED_LIST_ASSERT_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is high.
`define BFSL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that must hold in every cycle, reset included.
`define BFSL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BFSL_ASSERT(lbl, prop, msg)
`define BFSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/bfsl_pkg.sv @@
// Shared types, constants and helper functions of the ranked tally list.
// Used by bfsl_ctrl and bounded_frequency_sorted_list; depends on nothing else.
package bfsl_pkg;

   // Storage shape.
   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int OCC_W      = $clog2(CAPACITY + 1);

   // Field widths on the ports.
   localparam int KEY_PORT_W = 32;
   localparam int CNT_W      = 32;
   localparam int RANK_W     = 6;
   localparam int RANK_MAX   = (2 ** RANK_W) - 1;
   localparam int LIMIT_W    = 7;
   localparam int LIMIT_RST  = 64;

   // One stored list entry.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [CNT_W-1:0]    count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result of one item, handed from the sequencer to the output register.
   typedef struct packed {
      logic [RANK_W-1:0]     rank;
      logic [CNT_W-1:0]      count;
      logic                  was_new;
      logic                  evicted;
      logic [KEY_PORT_W-1:0] evicted_key;
   } result_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_BUB,
      ST_TAIL,
      ST_TAILW,
      ST_DONE
   } state_type;

   // Clamp the programmed limit into the range one to CAPACITY.
   function automatic logic [OCC_W-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
      if (v == '0) begin
         return OCC_W'(1);
      end else if (int'(v) > CAPACITY) begin
         return OCC_W'(CAPACITY);
      end else begin
         return OCC_W'(v);
      end
   endfunction

   // Saturate a list position to the rank field.
   function automatic logic [RANK_W-1:0] rank_sat(input logic [OCC_W-1:0] h);
      if (int'(h) > RANK_MAX) begin
         return RANK_W'(RANK_MAX);
      end else begin
         return RANK_W'(h);
      end
   endfunction

endpackage

@@ design/bfsl_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
// Generic; has no dependencies.
module bfsl_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port; a read and a write of the same address return old data.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/bfsl_ctrl.sv @@
// Sequencer of the ranked tally list: search, insertion shift and tail drop.
// Depends on bfsl_pkg, bfsl_ram and bounded_frequency_sorted_list_assert.svh.
`include "bounded_frequency_sorted_list_assert.svh"

module bfsl_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bfsl_pkg::KEY_PORT_W-1:0] start_key,
   input  logic [bfsl_pkg::OCC_W-1:0]      limit,
   output logic                            ready,
   output logic                            res_valid,
   input  logic                            res_take,
   output bfsl_pkg::result_type            result
);

   bfsl_pkg::state_type                   state_ff, state_in;
   logic [bfsl_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [bfsl_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic [bfsl_pkg::OCC_W-1:0]            occ_ff, occ_in;
   logic [bfsl_pkg::OCC_W-1:0]            hole_ff, hole_in;
   logic [bfsl_pkg::OCC_W-1:0]            rdidx_ff, rdidx_in;
   logic                                  new_ff, new_in;
   logic                                  evm_ff, evm_in;
   logic                                  evd_ff, evd_in;
   logic [bfsl_pkg::KEY_BITS-1:0]         evk_ff, evk_in;
   logic [bfsl_pkg::RANK_W-1:0]           rank_ff, rank_in;

   logic                                  mem_we;
   logic [bfsl_pkg::IDX_W-1:0]            mem_waddr;
   bfsl_pkg::entry_type                   mem_wdata;
   logic                                  mem_re;
   logic [bfsl_pkg::IDX_W-1:0]            mem_raddr;
   bfsl_pkg::entry_type                   rd_data;

   logic [bfsl_pkg::OCC_W-1:0]            last_idx;
   logic [bfsl_pkg::OCC_W-1:0]            hole_m1;
   logic [bfsl_pkg::OCC_W-1:0]            hole_m2;
   logic [bfsl_pkg::CNT_W-1:0]            cnt_next;
   logic                                  stop;
   logic                                  at_top;

   // Entry store, one entry read and one written per cycle.
   bfsl_ram #(
      .DEPTH (bfsl_pkg::CAPACITY),
      .WIDTH (bfsl_pkg::ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_data)
   );

   // Shared compare and increment logic working on the entry just read.
   assign last_idx = occ_ff - bfsl_pkg::OCC_W'(1);
   assign hole_m1  = hole_ff - bfsl_pkg::OCC_W'(1);
   assign hole_m2  = hole_ff - bfsl_pkg::OCC_W'(2);
   assign cnt_next = (rd_data.count == '1) ? rd_data.count
                                           : rd_data.count + bfsl_pkg::CNT_W'(1);
   assign stop     = rd_data.count > cnt_ff;
   // In drop mode the slot just past the list is the dropped tail and is never written.
   assign at_top   = evm_ff && (hole_ff == occ_ff);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsl_pkg::ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      cnt_ff   <= cnt_in;
      hole_ff  <= hole_in;
      rdidx_ff <= rdidx_in;
      new_ff   <= new_in;
      evm_ff   <= evm_in;
      evd_ff   <= evd_in;
      evk_ff   <= evk_in;
      rank_ff  <= rank_in;
   end

   // Next state and memory control.
   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      occ_in    = occ_ff;
      hole_in   = hole_ff;
      rdidx_in  = rdidx_ff;
      new_in    = new_ff;
      evm_in    = evm_ff;
      evd_in    = evd_ff;
      evk_in    = evk_ff;
      rank_in   = rank_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;

      case (state_ff)
         bfsl_pkg::ST_IDLE: begin
            if (start) begin
               key_in   = bfsl_pkg::KEY_BITS'(start_key);
               evk_in   = '0;
               evd_in   = 1'b0;
               rdidx_in = '0;
               if (occ_ff == '0) begin
                  // Empty list: the key goes straight to the head.
                  new_in   = 1'b1;
                  evm_in   = 1'b0;
                  cnt_in   = bfsl_pkg::CNT_W'(1);
                  hole_in  = '0;
                  state_in = bfsl_pkg::ST_BUB;
               end else begin
                  mem_re   = 1'b1;
                  mem_raddr = '0;
                  state_in = bfsl_pkg::ST_SRCH;
               end
            end
         end

         bfsl_pkg::ST_SRCH: begin
            if (rd_data.key == key_ff) begin
               // Listed key: lift it out and shift it up from its old slot.
               new_in  = 1'b0;
               evm_in  = 1'b0;
               cnt_in  = cnt_next;
               hole_in = rdidx_ff;
               if (rdidx_ff != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = bfsl_pkg::IDX_W'(rdidx_ff - bfsl_pkg::OCC_W'(1));
                  rdidx_in  = rdidx_ff - bfsl_pkg::OCC_W'(1);
               end
               state_in = bfsl_pkg::ST_BUB;
            end else if (rdidx_ff == last_idx) begin
               // New key: shift up from the end, dropping the tail when full.
               new_in    = 1'b1;
               cnt_in    = bfsl_pkg::CNT_W'(1);
               evm_in    = occ_ff >= limit;
               hole_in   = occ_ff;
               mem_re    = 1'b1;
               mem_raddr = bfsl_pkg::IDX_W'(last_idx);
               rdidx_in  = last_idx;
               state_in  = bfsl_pkg::ST_BUB;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = bfsl_pkg::IDX_W'(rdidx_ff + bfsl_pkg::OCC_W'(1));
               rdidx_in  = rdidx_ff + bfsl_pkg::OCC_W'(1);
            end
         end

         bfsl_pkg::ST_BUB: begin
            if (hole_ff == '0 || stop) begin
               // Place the key in the hole.
               if (at_top) begin
                  evk_in = key_ff;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = bfsl_pkg::IDX_W'(hole_ff);
                  mem_wdata = '{key: key_ff, count: cnt_ff};
               end
               rank_in = bfsl_pkg::rank_sat(hole_ff);
               if (new_ff) begin
                  evd_in = evm_ff;
                  if (!evm_ff) begin
                     occ_in = occ_ff + bfsl_pkg::OCC_W'(1);
                  end
                  state_in = bfsl_pkg::ST_DONE;
               end else if (occ_ff > limit) begin
                  state_in = bfsl_pkg::ST_TAIL;
               end else begin
                  state_in = bfsl_pkg::ST_DONE;
               end
            end else begin
               // Move the entry above the hole down one slot.
               if (at_top) begin
                  evk_in = rd_data.key;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = bfsl_pkg::IDX_W'(hole_ff);
                  mem_wdata = rd_data;
               end
               hole_in = hole_m1;
               if (hole_m1 != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = bfsl_pkg::IDX_W'(hole_m2);
                  rdidx_in  = hole_m2;
               end
            end
         end

         bfsl_pkg::ST_TAIL: begin
            // Read the tail after the placement write has landed.
            mem_re    = 1'b1;
            mem_raddr = bfsl_pkg::IDX_W'(last_idx);
            rdidx_in  = last_idx;
            state_in  = bfsl_pkg::ST_TAILW;
         end

         bfsl_pkg::ST_TAILW: begin
            evk_in   = rd_data.key;
            evd_in   = 1'b1;
            occ_in   = last_idx;
            state_in = bfsl_pkg::ST_DONE;
         end

         bfsl_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = bfsl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bfsl_pkg::ST_IDLE;
         end
      endcase
   end

   // Result of the finished item.
   assign ready              = state_ff == bfsl_pkg::ST_IDLE;
   assign res_valid          = state_ff == bfsl_pkg::ST_DONE;
   assign result.rank        = rank_ff;
   assign result.count       = cnt_ff;
   assign result.was_new     = new_ff;
   assign result.evicted     = evd_ff;
   assign result.evicted_key = bfsl_pkg::KEY_PORT_W'(evk_ff);

   // The list never holds more entries than the store has slots.
   `BFSL_ASSERT(a_occ_bound, occ_ff <= bfsl_pkg::OCC_W'(bfsl_pkg::CAPACITY), "occupancy above capacity")
   // While shifting, the data on the read port belongs to the slot above the hole.
   `BFSL_ASSERT(a_read_align, (state_ff == bfsl_pkg::ST_BUB && hole_ff != '0) |-> rdidx_ff == hole_m1, "shift read out of step with hole")
   // The store is written only while shifting, and never past its last slot.
   `BFSL_ASSERT(a_write_range, mem_we |-> (state_ff == bfsl_pkg::ST_BUB && hole_ff < bfsl_pkg::OCC_W'(bfsl_pkg::CAPACITY)), "entry write outside the shift phase or the store")

endmodule

@@ design/bounded_frequency_sorted_list.sv @@
// Top level of the ranked tally list: ports, limit register and result register.
// Depends on bfsl_pkg and bfsl_ctrl.
//
// Usage: each transfer on the req_ channel carries one 32-bit key. The block keeps
// up to csr_wdata-programmed list_limit keys (clamped to 1..64) ranked by count,
// highest first. For each key it returns one transfer on the rsp_ channel with the
// key's new rank and count, a new-key flag, and the key of any entry it dropped.
// The key search reads one stored entry per cycle through the single RAM read port,
// and the insertion shift then moves one entry per cycle. req_tready is high only
// while no item is in work; one item is handled at a time. A finished result waits
// in the output register; while the receiver holds rsp_tready low the next item can
// be taken, and its result waits in the sequencer until the register is free.
// Reset empties the list at once (no clearing pass) and sets the limit to 64.
// csr_we writes list_limit; write it only while the block is idle.
module bounded_frequency_sorted_list (
   input  logic        clock,
   input  logic        reset,
   // Input key channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [5:0] rank, [37:6] count, [69:38] evicted_key, rest 0
   output logic [1:0]  rsp_tuser,   // [0] was_new, [1] evicted
   // Configuration port.
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // list_limit
);

   logic [bfsl_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bfsl_pkg::result_type         rsp_data_ff, rsp_data_in;

   logic                         ctrl_ready;
   logic                         res_valid;
   logic                         res_take;
   bfsl_pkg::result_type         result;

   // Sequencer and entry store.
   bfsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && ctrl_ready),
      .start_key (req_tdata),
      .limit     (bfsl_pkg::eff_limit(limit_ff)),
      .ready     (ctrl_ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .result    (result)
   );

   // Limit register.
   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bfsl_pkg::LIMIT_W'(bfsl_pkg::LIMIT_RST);
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Output register: loads a finished result whenever it is empty or being drained.
   assign res_take     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_take ? res_valid : rsp_valid_ff;
   assign rsp_data_in  = (res_take && res_valid) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Port packing.
   assign req_tready = ctrl_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.evicted_key, rsp_data_ff.count, rsp_data_ff.rank};
   assign rsp_tuser  = {rsp_data_ff.evicted, rsp_data_ff.was_new};

endmodule

@@ tb/sv/bfsl_tb_pkg.sv @@
// Scoreboard for the ranked tally list: a predictor of the list and a queue of results.
// Depends on bfsl_pkg for the storage shape and the packed result layout.
package bfsl_tb_pkg;

   import bfsl_pkg::*;

   class rank_tally_scoreboard;

      // Predicted list contents and the programmed limit.
      logic [KEY_BITS-1:0] keys [CAPACITY];
      logic [CNT_W-1:0]    counts [CAPACITY];
      int                  occupancy;
      logic [LIMIT_W-1:0]  limit;

      result_type          expected_results [$];
      int                  failures;
      int                  results_seen;

      function new();
         occupancy    = 0;
         limit        = LIMIT_W'(LIMIT_RST);
         failures     = 0;
         results_seen = 0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] v);
         limit = v;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Move entries [from, to) up by one slot.
      function void shift_up(input int from, input int to);
         int i;
         for (i = to; i > from; i--) begin
            keys[i]   = keys[i - 1];
            counts[i] = counts[i - 1];
         end
      endfunction

      // Apply one accepted key to the predicted list and queue the result it causes.
      function void tally_key(input logic [KEY_BITS-1:0] key);
         int          lim;
         int          pos;
         int          p;
         int          i;
         bit          fresh;
         bit          ev;
         logic [31:0] cnt;
         logic [31:0] ev_key;
         result_type  r;
         lim = (limit == '0) ? 1 : ((int'(limit) > CAPACITY) ? CAPACITY : int'(limit));
         pos = occupancy;
         for (i = 0; i < occupancy; i++) begin
            if (keys[i] == key) begin
               pos = i;
               break;
            end
         end
         fresh  = (pos >= occupancy);
         ev     = 1'b0;
         ev_key = '0;
         p      = 0;
         if (fresh) begin
            // A new key goes just after the last entry whose count is above one.
            cnt = 32'd1;
            for (i = occupancy; i > 0; i--) begin
               if (counts[i - 1] > 32'd1) begin
                  p = i;
                  break;
               end
            end
            if (occupancy >= lim) begin
               ev = 1'b1;
               if (p >= occupancy) begin
                  // The new key itself is the tail and is never stored.
                  ev_key = key;
               end else begin
                  ev_key = keys[occupancy - 1];
                  shift_up(p, occupancy - 1);
                  keys[p]   = key;
                  counts[p] = cnt;
               end
            end else begin
               shift_up(p, occupancy);
               keys[p]   = key;
               counts[p] = cnt;
               occupancy++;
            end
         end else begin
            // A listed key moves to the front of the group holding its new count.
            cnt = counts[pos];
            if (cnt != '1) begin
               cnt++;
            end
            for (i = pos; i > 0; i--) begin
               if (cnt < counts[i - 1]) begin
                  p = i;
                  break;
               end
            end
            shift_up(p, pos);
            keys[p]   = key;
            counts[p] = cnt;
            if (occupancy > lim) begin
               ev     = 1'b1;
               ev_key = keys[occupancy - 1];
               occupancy--;
            end
         end
         r.rank        = (p > RANK_MAX) ? RANK_W'(RANK_MAX) : RANK_W'(p);
         r.count       = cnt;
         r.was_new     = fresh;
         r.evicted     = ev;
         r.evicted_key = ev_key;
         expected_results.push_back(r);
      endfunction

      // Compare one accepted result transfer with the oldest prediction.
      function void check_result(input logic [71:0] d, input logic [1:0] u);
         result_type e;
         bit         bad;
         results_seen++;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected result: tdata=%h tuser=%b", d, u);
            end
            return;
         end
         e   = expected_results.pop_front();
         bad = (d[5:0] !== e.rank) || (d[37:6] !== e.count) || (d[69:38] !== e.evicted_key)
               || (u[0] !== e.was_new) || (u[1] !== e.evicted);
         if (bad) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch at result %0d:", results_seen);
               $display("  expected rank=%0d count=%0d new=%0b evicted=%0b evicted_key=%h",
                        e.rank, e.count, e.was_new, e.evicted, e.evicted_key);
               $display("  actual   rank=%0d count=%0d new=%0b evicted=%0b evicted_key=%h",
                        d[5:0], d[37:6], u[0], u[1], d[69:38]);
            end
         end
      endfunction

   endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top of the ranked tally list testbench: clock, reset, key driver and result monitor.
// Depends on bfsl_pkg, bfsl_tb_pkg and the bounded_frequency_sorted_list RTL.
module tb_top;

   import bfsl_pkg::*;
   import bfsl_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int PHASE_ITEMS = 180;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [6:0]  csr_wdata  = '0;

   // Set for the last part of the run, where neither side idles.
   bit quiet_tail = 1'b0;

   rank_tally_scoreboard sb = new();

   bounded_frequency_sorted_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("bounded_frequency_sorted_list verification failed");
      $finish;
   end

   // Result monitor: checks each transfer and drives ready with random stall bursts.
   // Once, a long hold-off lets the block fill up and stall its input.
   initial begin
      int stall_left;
      bit pressure_done;
      stall_left    = 0;
      pressure_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (!pressure_done && !quiet_tail && sb.results_seen >= 250) begin
            stall_left    = 600;
            pressure_done = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   // Offer one key, with an optional idle burst first, and wait for its transfer.
   task automatic send_key(input logic [31:0] k);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= k;
      do @(posedge clock); while (!req_tready);
      sb.tally_key(k);
   endtask

   // Write the limit once every predicted result has come back.
   task automatic write_limit(input logic [6:0] v);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_limit(v);
   endtask

   // One random phase: a skewed pool of keys sized to the limit, mixed with fully
   // random keys, so that counts spread out and the tail keeps turning over.
   task automatic run_phase(input logic [6:0] lim, input int n);
      logic [31:0] pool [96];
      int          eff;
      int          pool_n;
      int          i;
      logic [31:0] k;
      write_limit(lim);
      eff    = (lim == 0) ? 1 : ((lim > 64) ? 64 : int'(lim));
      pool_n = eff + eff / 2 + 2;
      if (pool_n > 96) begin
         pool_n = 96;
      end
      for (i = 0; i < 96; i++) begin
         pool[i] = $urandom;
      end
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            k = $urandom;
         end else begin
            k = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
         end
         send_key(k);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      logic [6:0] phase_limits [10];
      int         ph;
      phase_limits = '{7'd64, 7'd40, 7'd3, 7'd1, 7'd16, 7'd127, 7'd5, 7'd64, 7'd2, 7'd24};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limit: two keys of count three, one of count one.
      repeat (3) send_key(32'h1234_5678);
      repeat (3) send_key(32'h9ABC_DEF0);
      send_key(32'h0F0F_0F0F);
      // Limit lowered below occupancy: the updated key is the tail and is dropped.
      write_limit(7'd2);
      send_key(32'h0F0F_0F0F);
      // A new key with every listed count above one drops itself.
      send_key(32'h3C3C_3C3C);
      // A limit of zero acts as one.
      write_limit(7'd0);
      send_key(32'h1234_5678);
      send_key(32'h0000_0000);
      // Out-of-range limit clamps to the capacity; extreme key values.
      write_limit(7'd127);
      send_key(32'hFFFF_FFFF);
      send_key(32'h0000_0000);
      send_key(32'hAAAA_AAAA);
      send_key(32'h5555_5555);
      send_key(32'hFFFF_FFFF);
      send_key(32'h0000_0000);
      send_key(32'h0000_0000);
      write_limit(7'd1);
      send_key(32'h8000_0001);
      send_key(32'h8000_0001);
      send_key(32'h7FFF_FFFE);
      // The saturating count cannot be reached in a run of this length.

      // Random phases; the last one runs with no idling on either side.
      for (ph = 0; ph < 10; ph++) begin
         if (ph == 9) begin
            quiet_tail = 1'b1;
         end
         run_phase(phase_limits[ph], PHASE_ITEMS);
      end

      // Drain, then give the block time to show any stray result.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("bounded_frequency_sorted_list verification clean");
      end else begin
         $display("bounded_frequency_sorted_list verification failed");
      end
      $finish;
   end

endmodule
